// File: hdl/ihex_pkg.sv
// Shared types, constants and the hex digit mapping for the Intel HEX decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihex_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned OFFS_W  = 16;
    localparam int unsigned INDEX_W = POS_W - 1;

    localparam logic [ADDR_W-1:0] FLASH_BASE_RESET = 32'h0806_0000;

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

    // record field positions, the colon being position 0
    localparam logic [POS_W-1:0] POS_MAX      = 10'd1023;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 10'd2;
    localparam logic [POS_W-1:0] POS_OFFS_HI  = 10'd3;
    localparam logic [POS_W-1:0] POS_OFFS_LO  = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE_LO  = 10'd8;
    localparam logic [POS_W-1:0] DATA_START   = 10'd9;
    localparam logic [POS_W-1:0] POS_DATA_LO  = 10'd10;

    localparam logic [BYTE_W-1:0] REC_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] REC_EOF  = 8'h01;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_byte;
    } t_result;

    // 'A'..'F' map to 10..15, anything else to (c - '0') mod 16
    function automatic logic [3:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] diff;
        begin
            diff = c - CHAR_ZERO;
            if (c >= CHAR_A && c <= CHAR_F) begin
                diff = c - CHAR_A + 8'd10;
            end
            digit_value = diff[3:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/ihex_if.sv
// Valid/ready channel interfaces for the Intel HEX decoder: characters in,
// results out, and the base address write port. Uses ihex_pkg.
`default_nettype none

interface ihex_char_if;
    import ihex_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_in;
    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_result_if;
    import ihex_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_byte;
    modport source (output valid, output kind, output write_address,
                    output write_byte, input ready);
    modport sink   (input valid, input kind, input write_address,
                    input write_byte, output ready);
endinterface

interface ihex_cfg_if;
    import ihex_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] flash_base;
    modport source (output valid, output flash_base, input ready);
    modport sink   (input valid, input flash_base, output ready);
endinterface

`default_nettype wire

// File: hdl/ihex_parse.sv
// Record parser: field position tracking and decode of one character per step.
// Depends on ihex_pkg.
`default_nettype none

module ihex_parse
    import ihex_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_char,
    input  wire logic [ADDR_W-1:0] i_flash_base,
    output logic                   o_res_valid,
    output t_result                o_res
);

    logic              r_in_record, n_in_record;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_byte_count, n_byte_count;
    logic [OFFS_W-1:0] r_offset, n_offset;
    logic [BYTE_W-1:0] r_record_kind, n_record_kind;
    logic [3:0]        r_high_nibble, n_high_nibble;
    logic              r_done, n_done;

    logic [3:0]         digit;
    logic [BYTE_W-1:0]  full;
    logic [POS_W-1:0]   pos_rel;
    logic [INDEX_W-1:0] index;
    logic               bump_pos;

    assign digit   = digit_value(i_char);
    assign full    = {r_high_nibble, digit};
    assign pos_rel = r_pos - DATA_START;
    assign index   = pos_rel[POS_W-1:1];

    always_comb begin
        n_in_record   = r_in_record;
        n_pos         = r_pos;
        n_byte_count  = r_byte_count;
        n_offset      = r_offset;
        n_record_kind = r_record_kind;
        n_high_nibble = r_high_nibble;
        n_done        = r_done;
        bump_pos      = 1'b0;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (!r_done) begin
            if (i_char == CHAR_COLON) begin
                n_in_record = 1'b1;
                n_pos       = 10'd1;
            end else if (r_in_record) begin
                bump_pos = 1'b1;
                if (r_pos >= POS_OFFS_HI && r_pos <= POS_OFFS_LO) begin
                    n_offset = {r_offset[OFFS_W-5:0], digit};
                end else if (r_pos[0]) begin
                    n_high_nibble = digit;
                end else if (r_pos == POS_LEN_LO) begin
                    n_byte_count = full;
                end else if (r_pos == POS_TYPE_LO) begin
                    n_record_kind = full;
                    if (full == REC_EOF) begin
                        n_done      = 1'b1;
                        n_in_record = 1'b0;
                        bump_pos    = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_EOF;
                    end else if (full != REC_DATA) begin
                        // unknown type: skip to the next colon
                        n_in_record = 1'b0;
                        bump_pos    = 1'b0;
                    end
                end else if (r_pos >= POS_DATA_LO) begin
                    if (r_record_kind == REC_DATA && {1'b0, r_byte_count} > index) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_DATA;
                        o_res.write_address = i_flash_base
                                            + {{(ADDR_W-OFFS_W){1'b0}}, r_offset}
                                            + {{(ADDR_W-INDEX_W){1'b0}}, index};
                        o_res.write_byte    = full;
                    end
                end
                if (bump_pos && r_pos < POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record   <= 1'b0;
            r_pos         <= '0;
            r_byte_count  <= '0;
            r_offset      <= '0;
            r_record_kind <= '0;
            r_high_nibble <= '0;
            r_done        <= 1'b0;
        end else if (i_step) begin
            r_in_record   <= n_in_record;
            r_pos         <= n_pos;
            r_byte_count  <= n_byte_count;
            r_offset      <= n_offset;
            r_record_kind <= n_record_kind;
            r_high_nibble <= n_high_nibble;
            r_done        <= n_done;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ihex_out_reg.sv
// Result register driving the output channel.
// Depends on ihex_pkg and ihex_result_if.
`default_nettype none

module ihex_out_reg
    import ihex_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire logic     i_valid,
    input  wire t_result  i_res,
    output logic          o_free,
    ihex_result_if.source o_result
);

    logic    r_valid;
    t_result r_res;

    // slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.kind          = r_res.kind;
    assign o_result.write_address = r_res.write_address;
    assign o_result.write_byte    = r_res.write_byte;

endmodule

`default_nettype wire

// File: hdl/intel_hex_record_decoder_unit.sv
// Top level of the Intel HEX record decoder: input register, base address
// register, parser and result register. Depends on ihex_pkg and ihex_if.
//
// Usage:
//   i_char   : one ASCII character per beat. A ':' opens a record; length,
//              offset and type follow, then data digit pairs and checksum.
//   o_result : one beat per data byte of a type 00 record (kind 0, address
//              flash_base + offset + byte index, wrapping at 2^32), and one
//              beat with kind 1 for the end-of-file record (address and byte
//              zero). Other record types, checksums and text outside a record
//              produce nothing. After end of file all input is swallowed.
//   i_cfg    : writes flash_base; always ready. Write only while idle.
// Path: a character is held in the input register, decoded by the parser
//   once the result slot is free, and its result registered for o_result.
// Throughput: one character per cycle unless o_result stalls. The input
//   register and the result register are separate stages, so a new
//   character is taken while a result waits. On a stall of o_result the held
//   character waits in the input register; i_char.ready drops once it is full.
// Reset (synchronous, active low): parser state cleared, result and input
//   registers emptied, flash_base back to 0x08060000.
`default_nettype none

module intel_hex_record_decoder_unit
    import ihex_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ihex_char_if.sink     i_char,
    ihex_cfg_if.sink      i_cfg,
    ihex_result_if.source o_result
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_char;
    logic [ADDR_W-1:0] r_flash_base;

    logic    out_free;
    logic    step;
    logic    res_valid;
    t_result res;

    // a held character is decoded once the result slot can take its output
    assign step         = r_in_valid && out_free;
    assign i_char.ready = !r_in_valid || step;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base <= FLASH_BASE_RESET;
        end else if (i_cfg.valid) begin
            r_flash_base <= i_cfg.flash_base;
        end
    end

    ihex_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_char       (r_char),
        .i_flash_base (r_flash_base),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    ihex_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_valid  (res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
